/* src/ssb_pkg.sv */
// Shared types and constants for the scrolling segment banner.
// Holds the banner reset pattern, the period constants and the control struct.
// No dependencies.
package ssb_pkg;

  localparam int BannerLength = 20;
  localparam int SegWidth     = 8;
  localparam int PeriodWidth  = 32;
  localparam int KeyWidth     = 4;

  localparam logic [PeriodWidth-1:0] DefaultPeriod = 32'd50000000;
  localparam logic [PeriodWidth-1:0] PeriodMax     = 32'hFFFF_FFFF;
  localparam logic [PeriodWidth-1:0] PeriodMin     = 32'd1;

  // Key codes, bit n is key n.
  localparam logic [KeyWidth-1:0] KeyPause  = 4'b0001;
  localparam logic [KeyWidth-1:0] KeyFaster = 4'b0010;
  localparam logic [KeyWidth-1:0] KeySlower = 4'b0100;
  localparam logic [KeyWidth-1:0] KeyDir    = 4'b1000;
  localparam logic [KeyWidth-1:0] KeyNone   = 4'b0000;

  typedef logic [BannerLength-1:0][SegWidth-1:0] banner_t;

  // Step controls in force after key handling.
  typedef struct packed {
    logic                   scroll_on;
    logic                   rotate_left;
    logic [PeriodWidth-1:0] period;
  } ssb_ctrl_t;

  // Banner after reset: "U OF T ECE-243" as segment codes, with blanks between words, then blanks.
  function automatic banner_t banner_reset();
    banner_t b;
    b = '0;
    b[0]  = 8'h3E;
    b[1]  = 8'h00;
    b[2]  = 8'h5C;
    b[3]  = 8'h71;
    b[4]  = 8'h00;
    b[5]  = 8'h78;
    b[6]  = 8'h00;
    b[7]  = 8'h79;
    b[8]  = 8'h39;
    b[9]  = 8'h79;
    b[10] = 8'h40;
    b[11] = 8'h5B;
    b[12] = 8'h66;
    b[13] = 8'h4F;
    return b;
  endfunction

endpackage

/* src/ssb_key_ctrl.sv */
// Key latches, pause and direction flags, and the step period register.
// Uses ssb_pkg for widths, key codes and the control struct.
module ssb_key_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [ssb_pkg::KeyWidth-1:0]    keys,
  input  logic                            cfg_we,
  input  logic [ssb_pkg::PeriodWidth-1:0] cfg_wdata,
  output logic [ssb_pkg::PeriodWidth-1:0] period,
  output ssb_pkg::ssb_ctrl_t              ctrl_next
);

  logic [ssb_pkg::KeyWidth-1:0]    latches;
  logic [ssb_pkg::KeyWidth-1:0]    latches_next;
  logic                            scroll_on;
  logic                            rotate_left;
  logic [ssb_pkg::PeriodWidth-1:0] halved;
  logic [ssb_pkg::PeriodWidth-1:0] doubled;

  assign halved  = (period[ssb_pkg::PeriodWidth-1:1] == '0) ? ssb_pkg::PeriodMin
                 : {1'b0, period[ssb_pkg::PeriodWidth-1:1]};
  assign doubled = period[ssb_pkg::PeriodWidth-1] ? ssb_pkg::PeriodMax
                 : {period[ssb_pkg::PeriodWidth-2:0], 1'b0};

  always_comb begin
    latches_next          = latches;
    ctrl_next.scroll_on   = scroll_on;
    ctrl_next.rotate_left = rotate_left;
    ctrl_next.period      = period;
    if (keys == ssb_pkg::KeyPause || keys == ssb_pkg::KeyFaster ||
        keys == ssb_pkg::KeySlower || keys == ssb_pkg::KeyDir) begin
      latches_next = latches | keys;
    end else if (keys == ssb_pkg::KeyNone) begin
      if ((latches & ssb_pkg::KeyPause) != '0) begin
        latches_next        = latches & ~ssb_pkg::KeyPause;
        ctrl_next.scroll_on = ~scroll_on;
      end else if ((latches & ssb_pkg::KeyFaster) != '0) begin
        latches_next     = latches & ~ssb_pkg::KeyFaster;
        ctrl_next.period = halved;
      end else if ((latches & ssb_pkg::KeySlower) != '0) begin
        latches_next     = latches & ~ssb_pkg::KeySlower;
        ctrl_next.period = doubled;
      end else if ((latches & ssb_pkg::KeyDir) != '0) begin
        latches_next          = latches & ~ssb_pkg::KeyDir;
        ctrl_next.rotate_left = ~rotate_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latches     <= '0;
      scroll_on   <= 1'b1;
      rotate_left <= 1'b1;
      period      <= ssb_pkg::DefaultPeriod;
    end else if (cfg_we) begin
      // A zero period behaves as one tick.
      period <= (cfg_wdata == '0) ? ssb_pkg::PeriodMin : cfg_wdata;
    end else if (step) begin
      latches     <= latches_next;
      scroll_on   <= ctrl_next.scroll_on;
      rotate_left <= ctrl_next.rotate_left;
      period      <= ctrl_next.period;
    end
  end

endmodule

/* src/ssb_banner.sv */
// Banner store with one-entry rotation and the six-digit segment readout.
// Uses ssb_pkg for the banner type, reset pattern and control struct.
module ssb_banner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  ssb_pkg::ssb_ctrl_t   ctrl,
  output logic [31:0]          digits_low,
  output logic [15:0]          digits_high
);

  ssb_pkg::banner_t banner;
  ssb_pkg::banner_t banner_next;

  always_comb begin
    banner_next = banner;
    if (ctrl.scroll_on) begin
      if (ctrl.rotate_left) begin
        for (int i = 0; i < ssb_pkg::BannerLength - 1; i++) begin
          banner_next[i] = banner[i+1];
        end
        banner_next[ssb_pkg::BannerLength-1] = banner[0];
      end else begin
        for (int i = 1; i < ssb_pkg::BannerLength; i++) begin
          banner_next[i] = banner[i-1];
        end
        banner_next[0] = banner[ssb_pkg::BannerLength-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      banner <= ssb_pkg::banner_reset();
    end else if (step) begin
      banner <= banner_next;
    end
  end

  assign digits_low  = {banner[2], banner[3], banner[4], banner[5]};
  assign digits_high = {banner[0], banner[1]};

endmodule

/* src/scrolling_segment_banner_core.sv */
// Top level of the scrolling segment banner: tick counter and result register.
// Instantiates ssb_key_ctrl and ssb_banner; uses ssb_pkg.
//
// Each request on the s_ channel is one clock tick carrying the four key
// levels. A tick counter counts requests; when it reaches the step period it
// restarts and one step runs, which handles the keys and emits one result on
// the m_ channel with the six leftmost banner digits, the scroll and direction
// flags and the period now in force. Ticks that run no step give no result.
// Results appear in the cycle after the tick request that caused them.
// A request is taken in every cycle while the result register is empty or
// being drained, so the sustained rate is one tick per cycle. When the
// receiver stalls with a result waiting, s_tready drops until it is taken.
// The cfg_we/cfg_wdata port loads the step period directly; zero acts as one.
// Reset restores a period of 50000000 ticks, scrolling on, leftward motion,
// clear key latches, the default banner and an empty result register.
module scrolling_segment_banner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] key_levels, [7:4] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] digits_low_word, [47:32] digits_high_word, [48] scrolling_on,
  // [49] rotate_left, [81:50] current_period, [87:82] zero
  output logic [87:0] m_tdata,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic                            accept;
  logic                            step;
  logic [ssb_pkg::PeriodWidth-1:0] tick_count;
  logic [ssb_pkg::PeriodWidth-1:0] tick_count_next;
  logic [ssb_pkg::PeriodWidth-1:0] period;
  ssb_pkg::ssb_ctrl_t              ctrl_next;
  logic [31:0]                     digits_low;
  logic [15:0]                     digits_high;

  assign s_tready        = ~m_tvalid | m_tready;
  assign accept          = s_tvalid & s_tready;
  assign tick_count_next = tick_count + 32'd1;
  assign step            = accept & (tick_count_next >= period);

  ssb_key_ctrl u_key_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .keys      (s_tdata[ssb_pkg::KeyWidth-1:0]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .period    (period),
    .ctrl_next (ctrl_next)
  );

  ssb_banner u_banner (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ctrl        (ctrl_next),
    .digits_low  (digits_low),
    .digits_high (digits_high)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (accept) begin
      tick_count <= step ? '0 : tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {6'b0, ctrl_next.period, ctrl_next.rotate_left, ctrl_next.scroll_on,
                  digits_high, digits_low};
    end
  end

endmodule
